>>> rtl/core/hvhc_pkg.sv
// Shared types and constants for the hysteresis valve and its windowed open counter.
package hvhc_pkg;

	localparam int unsigned WINDOW_SECONDS_DEF = 3600;
	localparam int unsigned BUCKET_BITS_DEF    = 16;
	localparam int unsigned TOTAL_BITS         = 28;
	localparam int unsigned THR_BITS           = 15;
	localparam int unsigned SEC_BITS           = 32;
	localparam int unsigned PRES_BITS          = 16;
	localparam int unsigned APB_AW             = 3;
	localparam int unsigned APB_DW             = 32;

	typedef enum logic [0:0] {
		REG_OPEN_THRESHOLD  = 1'b0,
		REG_HYSTERESIS_BAND = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_MOD,
		ST_FULL_CLR,
		ST_CLR_RD,
		ST_CLR_WR,
		ST_INC_RD,
		ST_INC_WR,
		ST_DONE
	} ring_state_t;

	typedef struct packed {
		logic                start;
		logic                open;
		logic [SEC_BITS-1:0] now;
		logic                ack;
	} ring_req_t;

	typedef struct packed {
		logic                  idle;
		logic                  done;
		logic [TOTAL_BITS-1:0] total;
	} ring_rsp_t;

endpackage

>>> rtl/core/hvhc_in_if.sv
// Request channel carrying one pressure sample with override and time.
interface hvhc_in_if import hvhc_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        manual_override;
	logic                        manual_on;
	logic signed [PRES_BITS-1:0] pressure;
	logic [SEC_BITS-1:0]         now_second;

	modport source (output valid, manual_override, manual_on, pressure, now_second,
		input ready);
	modport sink (input valid, manual_override, manual_on, pressure, now_second,
		output ready);
endinterface

>>> rtl/core/hvhc_out_if.sv
// Result channel carrying valve state and windowed open count.
interface hvhc_out_if import hvhc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  valve_open;
	logic [TOTAL_BITS-1:0] open_count_in_window;

	modport source (output valid, valve_open, open_count_in_window, input ready);
	modport sink (input valid, valve_open, open_count_in_window, output ready);
endinterface

>>> rtl/core/hvhc_mod.sv
// Remainder of a 32-bit second by the window length, by reciprocal multiplication.
module hvhc_mod import hvhc_pkg::*; #(
	parameter int unsigned WINDOW_SECONDS = WINDOW_SECONDS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [SEC_BITS-1:0]                      x,
	output logic                                     done,
	output logic [$clog2(WINDOW_SECONDS)-1:0]        rem
);
	localparam int unsigned IW = $clog2(WINDOW_SECONDS);
	// quotient = (x * RECIP) >> SH, exact for every 32-bit x; RECIP = 2^32 + RECIP_LO
	localparam int unsigned         SH       = SEC_BITS + IW;
	localparam logic [63:0]         RECIP    =
		((64'd1 << SH) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS);
	localparam logic [SEC_BITS-1:0] RECIP_LO = RECIP[SEC_BITS-1:0];
	localparam logic [SEC_BITS-1:0] WIN      = SEC_BITS'(WINDOW_SECONDS);

	logic                  vld_s1, vld_s2, vld_s3;
	logic [SEC_BITS-1:0]   x_s1;
	logic [SEC_BITS-1:0]   quo_s2;
	logic [IW-1:0]         rem_s3;
	logic [2*SEC_BITS-1:0] lo_prod;
	logic [2*SEC_BITS:0]   prod;
	logic [SEC_BITS-1:0]   quo, back, diff;

	// stage 1: 32x32 product plus the implicit 2^32 term; stage 2: x - q*W
	always_comb begin
		lo_prod = {{SEC_BITS{1'b0}}, x_s1} * {{SEC_BITS{1'b0}}, RECIP_LO};
		prod    = {1'b0, x_s1, {SEC_BITS{1'b0}}} + {1'b0, lo_prod};
		quo     = SEC_BITS'(prod >> SH);
		back    = quo_s2 * WIN;
		diff    = x_s1 - back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// operand held until the next start
	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= x;
		end
		quo_s2 <= quo;
		rem_s3 <= diff[IW-1:0];
	end

	assign done = vld_s3;
	assign rem  = rem_s3;
endmodule

>>> rtl/core/hvhc_ring.sv
// Bucket ring memory with the sequencer that ages, clears and bumps buckets.
module hvhc_ring import hvhc_pkg::*; #(
	parameter int unsigned WINDOW_SECONDS = WINDOW_SECONDS_DEF,
	parameter int unsigned BUCKET_BITS    = BUCKET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_req_t req,
	output ring_rsp_t rsp
);
	localparam int unsigned IW = $clog2(WINDOW_SECONDS);
	localparam int unsigned CW = (BUCKET_BITS > TOTAL_BITS) ? BUCKET_BITS : TOTAL_BITS;
	localparam logic [IW-1:0]          IDX_LAST = IW'(WINDOW_SECONDS-1);
	localparam logic [SEC_BITS-1:0]    WIN      = SEC_BITS'(WINDOW_SECONDS);
	localparam logic [BUCKET_BITS-1:0] BMAX     = '1;
	localparam logic [TOTAL_BITS-1:0]  TMAX     = '1;

	ring_state_t st_q, st_d;

	logic [SEC_BITS-1:0]   last_q, last_d;
	logic [IW-1:0]         last_idx_q, last_idx_d;
	logic [TOTAL_BITS-1:0] total_q, total_d;
	logic [IW-1:0]         clr_cnt_q, clr_cnt_d;
	logic [SEC_BITS-1:0]   sec_q, sec_d;
	logic [IW-1:0]         idx_q, idx_d;
	logic [SEC_BITS-1:0]   now_q, now_d;
	logic                  open_q, open_d;
	logic                  zero_q, zero_d;
	logic                  full_q, full_d;

	logic [SEC_BITS-1:0]    eff_last, elapsed, sec_inc, last_inc;
	logic [BUCKET_BITS-1:0] bucket;
	logic [CW-1:0]          b_ext, t_ext;

	logic [BUCKET_BITS-1:0] mem [WINDOW_SECONDS];
	logic                   mem_we;
	logic [IW-1:0]          mem_waddr, mem_raddr;
	logic [BUCKET_BITS-1:0] mem_wdata, rd_q;

	logic          mod_start, mod_done;
	logic [IW-1:0] mod_rem;

	// next ring index; a 32-bit wrap of the second lands on bucket zero
	function automatic logic [IW-1:0] idx_step(input logic [IW-1:0] i,
		input logic [SEC_BITS-1:0] s);
		if (s == '0) begin
			return '0;
		end else if (i == IDX_LAST) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	hvhc_mod #(
		.WINDOW_SECONDS(WINDOW_SECONDS)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.x     (req.now),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_comb begin
		st_d       = st_q;
		last_d     = last_q;
		last_idx_d = last_idx_q;
		total_d    = total_q;
		clr_cnt_d  = clr_cnt_q;
		sec_d      = sec_q;
		idx_d      = idx_q;
		now_d      = now_q;
		open_d     = open_q;
		zero_d     = zero_q;
		full_d     = full_q;
		mem_we     = 1'b0;
		mem_waddr  = idx_q;
		mem_wdata  = '0;
		mem_raddr  = idx_q;
		mod_start  = 1'b0;
		eff_last   = (last_q == '0) ? req.now : last_q;
		elapsed    = req.now - eff_last;
		sec_inc    = sec_q + SEC_BITS'(1);
		last_inc   = last_q + SEC_BITS'(1);
		bucket     = zero_q ? '0 : rd_q;
		b_ext      = CW'(rd_q);
		t_ext      = CW'(total_q);
		unique case (st_q)
			ST_INIT_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				if (clr_cnt_q == IDX_LAST) begin
					clr_cnt_d = '0;
					st_d      = ST_IDLE;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (req.start) begin
					now_d  = req.now;
					open_d = req.open;
					zero_d = 1'b0;
					full_d = 1'b0;
					if (last_q == '0) begin
						mod_start = 1'b1;
						st_d      = ST_MOD;
					end else if (elapsed >= WIN) begin
						mod_start = 1'b1;
						full_d    = 1'b1;
						total_d   = '0;
						st_d      = ST_MOD;
					end else if (elapsed == '0) begin
						idx_d = last_idx_q;
						st_d  = ST_INC_RD;
					end else begin
						sec_d = last_inc;
						idx_d = idx_step(last_idx_q, last_inc);
						st_d  = ST_CLR_RD;
					end
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					idx_d = mod_rem;
					if (full_q) begin
						zero_d = 1'b1;
						st_d   = ST_FULL_CLR;
					end else begin
						st_d = ST_INC_RD;
					end
				end
			end
			ST_FULL_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				if (clr_cnt_q == IDX_LAST) begin
					clr_cnt_d = '0;
					st_d      = ST_INC_WR;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			ST_CLR_RD: begin
				st_d = ST_CLR_WR;
			end
			ST_CLR_WR: begin
				total_d = (b_ext > t_ext) ? '0 : TOTAL_BITS'(t_ext - b_ext);
				mem_we  = 1'b1;
				if (sec_q == now_q) begin
					// the current bucket was just aged out, so it reads as empty
					zero_d = 1'b1;
					st_d   = ST_INC_WR;
				end else begin
					sec_d = sec_inc;
					idx_d = idx_step(idx_q, sec_inc);
					st_d  = ST_CLR_RD;
				end
			end
			ST_INC_RD: begin
				st_d = ST_INC_WR;
			end
			ST_INC_WR: begin
				if (open_q && (bucket != BMAX)) begin
					mem_we    = 1'b1;
					mem_wdata = bucket + 1'b1;
					if (total_q != TMAX) begin
						total_d = total_q + 1'b1;
					end
				end
				last_d     = now_q;
				last_idx_d = idx_q;
				st_d       = ST_DONE;
			end
			ST_DONE: begin
				if (req.ack) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_INIT_CLR;
			last_q     <= '0;
			last_idx_q <= '0;
			total_q    <= '0;
			clr_cnt_q  <= '0;
		end else begin
			st_q       <= st_d;
			last_q     <= last_d;
			last_idx_q <= last_idx_d;
			total_q    <= total_d;
			clr_cnt_q  <= clr_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		sec_q  <= sec_d;
		idx_q  <= idx_d;
		now_q  <= now_d;
		open_q <= open_d;
		zero_q <= zero_d;
		full_q <= full_d;
	end

	assign rsp.idle  = (st_q == ST_IDLE);
	assign rsp.done  = (st_q == ST_DONE);
	assign rsp.total = total_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (st_q == ST_IDLE))
		else $error("start while ring busy");

	a_mod_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (st_q == ST_MOD))
		else $error("remainder finished outside its wait state");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FULL_CLR) |-> (total_q == '0))
		else $error("total not cleared during full sweep");

	a_clr_loop: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_CLR_WR) && (sec_q != now_q)) |=> (st_q == ST_CLR_RD))
		else $error("aging walk ended early");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_DONE) && !req.ack) |=> (st_q == ST_DONE) && $stable(total_q))
		else $error("result dropped before handoff");
endmodule

>>> rtl/core/hysteresis_valve_with_hourly_counter_top.sv
// Top level: APB registers, valve decision and result register around the bucket ring.
// Result paths: an unchanged second bumps its bucket, a step of k seconds first ages out k
//   buckets, counter start takes the remainder, a gap of a window or more also clears all.
// Throughput: one request at a time; ready is low while the ring works.
// Reset (arst_n, async, low): registers and valve cleared, counter not started; the ring
//   then clears all WINDOW_SECONDS buckets before the first request is taken.
module hysteresis_valve_with_hourly_counter_top import hvhc_pkg::*; #(
	parameter int unsigned WINDOW_SECONDS = WINDOW_SECONDS_DEF,
	parameter int unsigned BUCKET_BITS    = BUCKET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	hvhc_in_if.sink           sample,
	hvhc_out_if.source        result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	// config registers
	logic [THR_BITS-1:0] thr_q, band_q;
	cfg_reg_t            reg_sel;

	// valve path
	logic                      valve_q, valve_next;
	logic signed [PRES_BITS:0] p_ext, thr_s, low_s;
	logic                      accept;

	// result register
	logic                  out_valid_q;
	logic                  out_valve_q;
	logic [TOTAL_BITS-1:0] out_total_q;

	ring_req_t ring_req;
	ring_rsp_t ring_rsp;

	// register i sits at byte 4*i; only bit 2 picks the register
	assign reg_sel = cfg_reg_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			band_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_OPEN_THRESHOLD:  thr_q  <= pwdata[THR_BITS-1:0];
				REG_HYSTERESIS_BAND: band_q <= pwdata[THR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_OPEN_THRESHOLD:  prdata = APB_DW'(thr_q);
			REG_HYSTERESIS_BAND: prdata = APB_DW'(band_q);
			default:             prdata = '0;
		endcase
	end

	// Hysteresis compare at 17 bits signed: the low trip point may go negative.
	always_comb begin
		p_ext = {sample.pressure[PRES_BITS-1], sample.pressure};
		thr_s = signed'({2'b00, thr_q});
		low_s = thr_s - signed'({2'b00, band_q});
		priority if (sample.manual_override) begin
			valve_next = sample.manual_on;
		end else if (p_ext > thr_s) begin
			valve_next = 1'b1;
		end else if (p_ext < low_s) begin
			valve_next = 1'b0;
		end else begin
			valve_next = valve_q;
		end
	end

	assign sample.ready = ring_rsp.idle;
	assign accept       = sample.valid && ring_rsp.idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_q <= 1'b0;
		end else if (accept) begin
			valve_q <= valve_next;
		end
	end

	// ring request: start with the new valve state; ack when the result slot is free
	assign ring_req.start = accept;
	assign ring_req.open  = valve_next;
	assign ring_req.now   = sample.now_second;
	assign ring_req.ack   = !out_valid_q || result.ready;

	hvhc_ring #(
		.WINDOW_SECONDS(WINDOW_SECONDS),
		.BUCKET_BITS   (BUCKET_BITS)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ring_req),
		.rsp   (ring_rsp)
	);

	// output register parts the ring from the result consumer; a held result
	// does not block the next request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ring_rsp.done && ring_req.ack) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_rsp.done && ring_req.ack) begin
			out_valve_q <= valve_q;
			out_total_q <= ring_rsp.total;
		end
	end

	assign result.valid                = out_valid_q;
	assign result.valve_open           = out_valve_q;
	assign result.open_count_in_window = out_total_q;
endmodule
